/* rtl/core/abc_pkg.sv */
// Shared types and constants for the articulation and bridge counter.
`timescale 1ns / 1ps

package abc_pkg;

    localparam int VTX_W            = 9;
    localparam int ART_W            = 9;
    localparam int BRG_W            = 11;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic             command;
        logic [VTX_W-1:0] edge_first;
        logic [VTX_W-1:0] edge_second;
    } t_in_item;

    typedef struct packed {
        logic [ART_W-1:0] articulation_count;
        logic [BRG_W-1:0] bridge_count;
        logic             load_error;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic start;
        logic pass_init;
        logic latch_cut;
        logic clr_step;
        logic rd_root;
        logic root_next;
        logic root_take;
        logic pop;
        logic latch_u;
        logic rd_scan;
        logic scan_next;
        logic rd_nb;
        logic nb_chk;
        logic pass_end;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic root_done;
        logic root_vis;
        logic sp_zero;
        logic scan_done;
        logic hit;
        logic finished;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/articulation_bridge_counter_top.sv */
// Top level of the articulation vertex and bridge counter.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------
//  config   | in        | i_cfg_we               | i_cfg_wdata (vertex_count)
//  input    | in        | i_in_valid / o_in_stall| i_in_item (t_in_item)
//  output   | out       | o_out_valid/i_out_stall| o_out_item (t_out_item)
//
// An add-edge item is taken while idle, one per cycle. A finish item runs
// 1 + n + E passes (n vertices, E stored edges); each pass sweeps the visited
// map, tries each candidate root, and for every popped vertex scans all stored
// edges in turn, reading the visited map for each neighbour found, so the serial
// edge scan sets the time. o_in_stall is high throughout; reset is synchronous,
// active low.
`timescale 1ns / 1ps

module articulation_bridge_counter_top #(
    parameter int MAX_VERTICES = abc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = abc_pkg::MAX_EDGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  abc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output abc_pkg::t_out_item o_out_item
);

    import abc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    abc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_item.command),
        .o_in_stall   (o_in_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    abc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_report_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.report |=> o_out_valid)
        else $error("report did not reach the output register");

    a_report_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.report |-> (!o_out_valid || !i_out_stall))
        else $error("report overwrote a waiting item");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_in_valid && !o_in_stall && (i_in_item.command == CMD_ADD)))
        else $error("edge loaded without an accepted add item");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.start, cmd.pass_init, cmd.clr_step, cmd.rd_root,
                  cmd.pop, cmd.rd_scan, cmd.nb_chk, cmd.pass_end, cmd.report}))
        else $error("conflicting datapath commands");
`endif

endmodule

/* rtl/core/abc_ram.sv */
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module abc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/abc_ctrl.sv */
// Sequencer for loading and the brute-force component passes.
`timescale 1ns / 1ps

module abc_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_command,
    output logic         o_in_stall,
    input  abc_pkg::t_sts i_sts,
    output abc_pkg::t_cmd o_cmd
);

    import abc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSTART = 4'd1;
    localparam logic [3:0] S_LATCH  = 4'd2;
    localparam logic [3:0] S_CLR    = 4'd3;
    localparam logic [3:0] S_ROOT   = 4'd4;
    localparam logic [3:0] S_RCHK   = 4'd5;
    localparam logic [3:0] S_POP    = 4'd6;
    localparam logic [3:0] S_PWAIT  = 4'd7;
    localparam logic [3:0] S_SCAN   = 4'd8;
    localparam logic [3:0] S_SCHK   = 4'd9;
    localparam logic [3:0] S_NCHK   = 4'd10;
    localparam logic [3:0] S_PEND   = 4'd11;
    localparam logic [3:0] S_NEXT   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_command == CMD_ADD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = S_PSTART;
                    end
                end
            end
            S_PSTART: begin
                cmd.pass_init = 1'b1;
                n_state       = S_LATCH;
            end
            S_LATCH: begin
                cmd.latch_cut = 1'b1;
                n_state       = S_CLR;
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = S_PEND;
                end else begin
                    cmd.rd_root = 1'b1;
                    n_state     = S_RCHK;
                end
            end
            S_RCHK: begin
                if (i_sts.root_vis) begin
                    cmd.root_next = 1'b1;
                    n_state       = S_ROOT;
                end else begin
                    cmd.root_take = 1'b1;
                    n_state       = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.sp_zero) begin
                    n_state = S_ROOT;
                end else begin
                    cmd.pop = 1'b1;
                    n_state = S_PWAIT;
                end
            end
            S_PWAIT: begin
                cmd.latch_u = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_POP;
                end else begin
                    cmd.rd_scan = 1'b1;
                    n_state     = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_sts.hit) begin
                    cmd.rd_nb = 1'b1;
                    n_state   = S_NCHK;
                end else begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_NCHK: begin
                cmd.nb_chk = 1'b1;
                n_state    = S_SCAN;
            end
            S_PEND: begin
                cmd.pass_end = 1'b1;
                n_state      = S_NEXT;
            end
            S_NEXT: begin
                n_state = i_sts.finished ? S_DONE : S_PSTART;
            end
            S_DONE: begin
                // hold until the output slot is free
                if (i_sts.out_free) begin
                    cmd.report = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/core/abc_dp.sv */
// Datapath: edge store, visited map, search stack, counters and result register.
`timescale 1ns / 1ps

module abc_dp #(
    parameter int MAX_VERTICES = abc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = abc_pkg::MAX_EDGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [8:0]            i_cfg_wdata,
    input  abc_pkg::t_in_item     i_in_item,
    input  abc_pkg::t_cmd         i_cmd,
    output abc_pkg::t_sts         o_sts,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output abc_pkg::t_out_item    o_out_item
);

    import abc_pkg::*;

    localparam int VAW    = $clog2(MAX_VERTICES + 1);
    localparam int SPW    = $clog2(MAX_VERTICES + 1);
    localparam int SAW    = $clog2(MAX_VERTICES);
    localparam int ETW    = $clog2(MAX_EDGES + 1);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_W = 2 * VTX_W;

    localparam logic [1:0] KIND_BASE = 2'd0;
    localparam logic [1:0] KIND_VERT = 2'd1;
    localparam logic [1:0] KIND_EDGE = 2'd2;

    logic [8:0]       r_vc;
    logic [ETW-1:0]   r_total;
    logic             r_drop;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [1:0]       r_kind;
    logic [VAW:0]     r_i;
    logic [ETW-1:0]   r_e;
    logic [VAW-1:0]   r_base;
    logic [VAW-1:0]   r_art;
    logic [ETW-1:0]   r_brg;
    logic [VAW-1:0]   r_clr;
    logic [VAW:0]     r_j;
    logic [VAW-1:0]   r_cnt;
    logic [SPW-1:0]   r_sp;
    logic [VTX_W-1:0] r_u;
    logic [ETW-1:0]   r_f;
    logic [VTX_W-1:0] r_nb;
    logic [VTX_W-1:0] r_xa;
    logic [VTX_W-1:0] r_xb;

    logic [VAW-1:0]    n_eff;
    logic              load_ok;
    logic [EDGE_W-1:0] edge_rd;
    logic [VTX_W-1:0]  ea;
    logic [VTX_W-1:0]  eb;
    logic [VTX_W-1:0]  nb_c;
    logic              adj;
    logic              cut_match;
    logic              vis_rd;
    logic              skip_hit;
    logic              push_ok;
    logic              gt;
    logic [SPW-1:0]    sp_m1;
    logic [VTX_W-1:0]  stk_rd;

    logic              vis_we;
    logic [VAW-1:0]    vis_waddr;
    logic              vis_wdata;
    logic              vis_re;
    logic [VAW-1:0]    vis_raddr;
    logic              stk_we;
    logic [SAW-1:0]    stk_waddr;
    logic [VTX_W-1:0]  stk_wdata;

    assign n_eff = (32'(r_vc) < MAX_VERTICES) ? VAW'(r_vc) : VAW'(MAX_VERTICES);

    assign load_ok = (i_in_item.edge_first != '0)
                  && (32'(i_in_item.edge_first) <= 32'(n_eff))
                  && (i_in_item.edge_second != '0)
                  && (32'(i_in_item.edge_second) <= 32'(n_eff))
                  && (r_total < ETW'(MAX_EDGES));

    assign ea        = edge_rd[EDGE_W-1:VTX_W];
    assign eb        = edge_rd[VTX_W-1:0];
    assign adj       = (ea == r_u) || (eb == r_u);
    assign nb_c      = (ea == r_u) ? eb : ea;
    // a cut edge takes every parallel copy with it
    assign cut_match = (r_kind == KIND_EDGE)
                    && (((ea == r_xa) && (eb == r_xb)) || ((ea == r_xb) && (eb == r_xa)));

    assign skip_hit = (r_kind == KIND_VERT) && ((VAW + 1)'(r_clr) == r_i);
    assign push_ok  = !vis_rd && (r_sp < SPW'(MAX_VERTICES));
    assign gt       = r_cnt > r_base;
    assign sp_m1    = r_sp - 1'b1;

    abc_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && load_ok),
        .i_waddr (r_total[EAW-1:0]),
        .i_wdata ({i_in_item.edge_first, i_in_item.edge_second}),
        .i_re    (i_cmd.pass_init || i_cmd.rd_scan),
        .i_raddr (i_cmd.pass_init ? r_e[EAW-1:0] : r_f[EAW-1:0]),
        .o_rdata (edge_rd)
    );

    assign vis_we    = i_cmd.clr_step || i_cmd.root_take || (i_cmd.nb_chk && push_ok);
    assign vis_waddr = i_cmd.clr_step  ? r_clr :
                       i_cmd.root_take ? r_j[VAW-1:0] : VAW'(r_nb);
    assign vis_wdata = i_cmd.clr_step ? skip_hit : 1'b1;
    assign vis_re    = i_cmd.rd_root || i_cmd.rd_nb;
    assign vis_raddr = i_cmd.rd_root ? r_j[VAW-1:0] : VAW'(nb_c);

    abc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VERTICES + 1)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_re    (vis_re),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rd)
    );

    assign stk_we    = i_cmd.root_take || (i_cmd.nb_chk && push_ok);
    assign stk_waddr = i_cmd.root_take ? '0 : r_sp[SAW-1:0];
    assign stk_wdata = i_cmd.root_take ? VTX_W'(r_j) : r_nb;

    abc_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (i_cmd.pop),
        .i_raddr (sp_m1[SAW-1:0]),
        .o_rdata (stk_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= 9'd1;
            r_total     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (load_ok) begin
                    r_total <= r_total + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.report) begin
                r_total     <= '0;
                r_drop      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out_item.articulation_count <= ART_W'(r_art);
            r_out_item.bridge_count       <= BRG_W'(r_brg);
            r_out_item.load_error         <= r_drop;
        end
        if (i_cmd.start) begin
            r_kind <= KIND_BASE;
            r_art  <= '0;
            r_brg  <= '0;
            r_i    <= (VAW + 1)'(1);
            r_e    <= '0;
        end
        if (i_cmd.pass_init) begin
            r_clr <= '0;
            r_j   <= (VAW + 1)'(1);
            r_cnt <= '0;
            r_sp  <= '0;
        end
        if (i_cmd.latch_cut) begin
            r_xa <= ea;
            r_xb <= eb;
        end
        if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
        if (i_cmd.root_next) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.root_take) begin
            r_j   <= r_j + 1'b1;
            r_cnt <= r_cnt + 1'b1;
            r_sp  <= SPW'(1);
        end
        if (i_cmd.pop) begin
            r_sp <= sp_m1;
        end
        if (i_cmd.latch_u) begin
            r_u <= stk_rd;
            r_f <= '0;
        end
        if (i_cmd.scan_next) begin
            r_f <= r_f + 1'b1;
        end
        if (i_cmd.rd_nb) begin
            r_nb <= nb_c;
        end
        if (i_cmd.nb_chk) begin
            r_f <= r_f + 1'b1;
            if (push_ok) begin
                r_sp <= r_sp + 1'b1;
            end
        end
        if (i_cmd.pass_end) begin
            case (r_kind)
                KIND_BASE: begin
                    r_base <= r_cnt;
                    r_kind <= (n_eff == '0) ? KIND_EDGE : KIND_VERT;
                end
                KIND_VERT: begin
                    if (gt) begin
                        r_art <= r_art + 1'b1;
                    end
                    if (r_i == (VAW + 1)'(n_eff)) begin
                        r_kind <= KIND_EDGE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: begin
                    if (gt) begin
                        r_brg <= r_brg + 1'b1;
                    end
                    r_e <= r_e + 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_clr == VAW'(MAX_VERTICES));
        o_sts.root_done = (r_j > (VAW + 1)'(n_eff));
        o_sts.root_vis  = vis_rd;
        o_sts.sp_zero   = (r_sp == '0);
        o_sts.scan_done = (r_f >= r_total);
        o_sts.hit       = adj && !cut_match;
        o_sts.finished  = (r_kind == KIND_EDGE) && (r_e >= r_total);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* tb/articulation_bridge_counter_top_tb.sv */
// Self-checking testbench for the articulation vertex and bridge counter.
`timescale 1ns / 1ps

module articulation_bridge_counter_top_tb;
    import abc_pkg::*;

    localparam int NVTX = 256;
    localparam int NEDGE = 1024;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    articulation_bridge_counter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // graph copy and bookkeeping
    logic [8:0]  graph_a [NEDGE];
    logic [8:0]  graph_b [NEDGE];
    int          graph_edges;
    logic        graph_dropped;
    logic [8:0]  vtx_reg;
    bit          seen [NVTX+1];
    logic [8:0]  dfs_stack [NVTX];
    t_out_item   pending_counts [$];
    int          fails = 0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #600ms;
        $display("** articulation_bridge_counter_top: FAILED **");
        $finish;
    end

    function automatic int eff_vertices();
        return (vtx_reg < NVTX) ? vtx_reg : NVTX;
    endfunction

    function automatic void flood(int root, bit cut, int xa, int xb);
        int sp;
        int u;
        int a;
        int b;
        int nb;
        seen[root] = 1'b1;
        dfs_stack[0] = root[8:0];
        sp = 1;
        while (sp > 0) begin
            sp--;
            u = dfs_stack[sp];
            for (int e = 0; e < graph_edges; e++) begin
                a = graph_a[e];
                b = graph_b[e];
                if (a == u) nb = b;
                else if (b == u) nb = a;
                else continue;
                if (cut && ((a == xa && b == xb) || (a == xb && b == xa))) continue;
                if (nb > NVTX) continue;
                if (!seen[nb] && sp < NVTX) begin
                    seen[nb] = 1'b1;
                    dfs_stack[sp] = nb[8:0];
                    sp++;
                end
            end
        end
    endfunction

    function automatic int count_components(int skip, bit cut, int xa, int xb);
        int cnt;
        cnt = 0;
        for (int j = 0; j <= NVTX; j++) seen[j] = 1'b0;
        if (skip >= 1 && skip <= NVTX) seen[skip] = 1'b1;
        for (int j = 1; j <= eff_vertices(); j++) begin
            if (!seen[j]) begin
                cnt++;
                flood(j, 1'b0 | cut, xa, xb);
            end
        end
        return cnt;
    endfunction

    // update the graph copy; queue the counts on a finish
    function automatic void apply_item(t_in_item it);
        int n;
        int base;
        int art;
        int brg;
        t_out_item res;
        n = eff_vertices();
        if (it.command == CMD_ADD) begin
            if (it.edge_first < 1 || it.edge_first > n || it.edge_second < 1 ||
                it.edge_second > n || graph_edges >= NEDGE) begin
                graph_dropped = 1'b1;
            end else begin
                graph_a[graph_edges] = it.edge_first;
                graph_b[graph_edges] = it.edge_second;
                graph_edges++;
            end
            return;
        end
        base = count_components(0, 1'b0, 0, 0);
        art = 0;
        brg = 0;
        for (int i = 1; i <= n; i++)
            if (count_components(i, 1'b0, 0, 0) > base) art++;
        for (int e = 0; e < graph_edges; e++)
            if (count_components(0, 1'b1, graph_a[e], graph_b[e]) > base) brg++;
        res.articulation_count = art[ART_W-1:0];
        res.bridge_count = brg[BRG_W-1:0];
        res.load_error = graph_dropped;
        pending_counts = {pending_counts, res};
        graph_edges = 0;
        graph_dropped = 1'b0;
    endfunction

    task automatic send_item(t_in_item it);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (in_stall);
        apply_item(it);
    endtask

    task automatic add_edge(int a, int b);
        t_in_item it;
        it.command = CMD_ADD;
        it.edge_first = a[8:0];
        it.edge_second = b[8:0];
        send_item(it);
    endtask

    task automatic finish_load();
        t_in_item it;
        it.command = CMD_FINISH;
        it.edge_first = 9'($urandom_range(0, 511));
        it.edge_second = 9'($urandom_range(0, 511));
        send_item(it);
    endtask

    // hold the sender until every expected result is in, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_vertices(int n);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= n[8:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        vtx_reg = n[8:0];
    endtask

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_counts.size() == 0) begin
                $error("result with no expectation waiting");
                fails++;
            end else begin
                want = pending_counts.pop_front();
                if (out_item.articulation_count !== want.articulation_count) begin
                    $error("articulation_count: expected %0d, actual %0d",
                           want.articulation_count, out_item.articulation_count);
                    fails++;
                end
                if (out_item.bridge_count !== want.bridge_count) begin
                    $error("bridge_count: expected %0d, actual %0d",
                           want.bridge_count, out_item.bridge_count);
                    fails++;
                end
                if (out_item.load_error !== want.load_error) begin
                    $error("load_error: expected %0d, actual %0d",
                           want.load_error, out_item.load_error);
                    fails++;
                end
            end
        end
    end

    // receiver stalls at random, in bursts of random length
    always @(posedge i_clk) begin
        if (!idle_en) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
    end

    task automatic test_directed();
        write_vertices(5);
        // triangle with a tail: one articulation vertex, one bridge
        add_edge(1, 2); add_edge(2, 3); add_edge(3, 1); add_edge(3, 4);
        finish_load();
        // parallel copies are cut together, so each still counts as a bridge; a self loop never does
        add_edge(1, 2); add_edge(2, 1); add_edge(2, 3); add_edge(4, 4);
        finish_load();
        // out-of-range endpoints are dropped
        add_edge(0, 1); add_edge(1, 6); add_edge(256, 2); add_edge(511, 511);
        add_edge(4, 5);
        finish_load();
        finish_load();
        write_vertices(0);
        add_edge(1, 1);
        finish_load();
        write_vertices(511);
        add_edge(1, 256); add_edge(256, 255); add_edge(256, 256); add_edge(257, 1);
        finish_load();
    endtask

    task automatic test_shrunk_count();
        write_vertices(8);
        add_edge(1, 7); add_edge(7, 2); add_edge(2, 3); add_edge(8, 4);
        write_vertices(4);
        finish_load();
    endtask

    task automatic test_store_full();
        write_vertices(1);
        for (int k = 0; k <= NEDGE; k++) add_edge(1, 1);
        finish_load();
    endtask

    task automatic test_random(int items);
        int sent;
        int n;
        int ne;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 3) == 0) write_vertices($urandom_range(1, 9));
            n = eff_vertices();
            ne = $urandom_range(0, 14);
            for (int k = 0; k < ne; k++) begin
                if ($urandom_range(0, 9) == 0)
                    add_edge($urandom_range(0, 511), $urandom_range(0, 511));
                else
                    add_edge($urandom_range(1, n), $urandom_range(1, n));
            end
            finish_load();
            sent += ne + 1;
        end
    endtask

    initial begin
        vtx_reg = 9'd1;
        graph_edges = 0;
        graph_dropped = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_shrunk_count();
        test_store_full();
        test_random(600);
        drain();
        idle_en = 1'b0;
        test_random(400);
        drain();
        if (fails == 0)
            $display("** articulation_bridge_counter_top: PASSED **");
        else
            $display("** articulation_bridge_counter_top: FAILED **");
        $finish;
    end

endmodule
